[design/text_console_cursor_engine_core_macros.svh]
// ----------------------------------------------------------------------------
// Text console cursor engine: assertion macros
// Concurrent assertion helpers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define TCCE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cursor engine assertion failed");
// The condition must never be true outside reset.
`define TCCE_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("cursor engine forbidden condition seen");
`else
`define TCCE_ASSERT(lbl, clk, rst, prop)
`define TCCE_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

[design/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared codes, command record and the tab phase table builder.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int unsigned TAB_STOP_DEF = 8;
  localparam int unsigned MAX_RESULTS  = 8;
  localparam int unsigned CNT_W        = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_W        = $clog2(MAX_RESULTS);
  localparam int unsigned TAB_REM_W    = 4;  // holds a remainder for tab stops up to 16
  localparam int unsigned CLEAR_LEN    = 7;
  localparam int unsigned BS_LEN       = 3;

  localparam logic [7:0] COLUMNS_RST = 8'd80;
  localparam logic [7:0] ROWS_RST    = 8'd25;

  // Input item modes.
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_CURSOR = 2'd2;

  // Configuration register indexes.
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Kinds of byte sequence the back end plays out.
  typedef enum logic [2:0] {
    K_STATUS = 3'd0,
    K_ECHO   = 3'd1,
    K_SPACES = 3'd2,
    K_BSSEQ  = 3'd3,
    K_CLEAR  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CNT_W-1:0]  count;   // number of beats, 1 to MAX_RESULTS
    logic [7:0]        ch;      // echoed byte for K_ECHO
    logic [7:0]        col;     // cursor after the item
    logic [7:0]        row;
  } cmd_t;

  typedef logic [TAB_REM_W-1:0] tab_lut_t [256];

  // Column modulo tab stop for every column, built by counting so no divider is needed.
  function automatic tab_lut_t mod_lut(input int unsigned tab);
    tab_lut_t    lut;
    int unsigned phase;
    phase = 0;
    for (int i = 0; i < 256; i++) begin
      lut[i] = phase[TAB_REM_W-1:0];
      if (phase + 1 == tab) phase = 0;
      else phase = phase + 1;
    end
    return lut;
  endfunction

  // Escape sequence ESC [ 2 J ESC [ H.
  function automatic logic [7:0] clear_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      IDX_W'(0): b = CH_ESC;
      IDX_W'(1): b = 8'h5B;
      IDX_W'(2): b = 8'h32;
      IDX_W'(3): b = 8'h4A;
      IDX_W'(4): b = CH_ESC;
      IDX_W'(5): b = 8'h5B;
      IDX_W'(6): b = 8'h48;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[design/tcce_front.sv]
// ----------------------------------------------------------------------------
// Cursor engine front end
// Accepts items, tracks cursor and discard state, and issues one command each.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_core_macros.svh"

module tcce_front #(
  parameter int unsigned TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // mode[1:0], char_code[9:2], new_col[17:10], new_row[25:18]
  input  logic          s_tlast,   // last_of_request
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  output tcce_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import tcce_pkg::*;

  localparam tab_lut_t MOD_LUT = mod_lut(TAB_STOP);

  logic [7:0] columns;
  logic [7:0] rows;
  logic [7:0] col;
  logic [7:0] row;
  logic       disc;
  logic [7:0] col_next;
  logic [7:0] row_next;
  logic       disc_next;

  logic [1:0] mode;
  logic [7:0] ch;
  logic [7:0] new_col;
  logic [7:0] new_row;
  logic       accept;

  logic [7:0] last_row;
  logic [8:0] row_inc;
  logic [7:0] row_adv;
  logic [8:0] col_inc;
  logic [TAB_REM_W-1:0] rem;
  logic [8:0] stop_gap;
  logic [8:0] room;
  logic [8:0] spaces;
  logic [8:0] tab_sum;

  assign mode    = s_tdata[1:0];
  assign ch      = s_tdata[9:2];
  assign new_col = s_tdata[17:10];
  assign new_row = s_tdata[25:18];

  assign s_tready  = cmd_ready;
  assign cmd_valid = s_tvalid;
  assign accept    = s_tvalid && cmd_ready;

  // Row advance, clamped at the last row.
  assign last_row = (rows == 8'd0) ? 8'd0 : rows - 8'd1;
  assign row_inc  = {1'b0, row} + 9'd1;
  assign row_adv  = (row_inc > {1'b0, last_row}) ? last_row : row_inc[7:0];
  assign col_inc  = {1'b0, col} + 9'd1;

  // Tab: spaces to the next stop, bounded by the screen width and the beat budget.
  assign rem      = MOD_LUT[col];
  assign stop_gap = 9'(TAB_STOP) - {{(9 - TAB_REM_W){1'b0}}, rem};
  assign room     = (col < columns) ? ({1'b0, columns} - {1'b0, col}) : 9'd0;
  always_comb begin
    spaces = stop_gap;
    if (room < spaces) spaces = room;
    if (9'(MAX_RESULTS) < spaces) spaces = 9'(MAX_RESULTS);
  end
  assign tab_sum = {1'b0, col} + spaces;

  always_comb begin
    col_next  = col;
    row_next  = row;
    disc_next = disc;
    cmd.kind  = K_STATUS;
    cmd.count = CNT_W'(1);
    cmd.ch    = ch;
    unique case (mode)
      MODE_WRITE: begin
        if (!disc) begin
          case (ch)
            CH_NUL: disc_next = 1'b1;
            CH_LF: begin
              cmd.kind = K_ECHO;
              col_next = 8'd0;
              row_next = row_adv;
            end
            CH_CR: col_next = 8'd0;
            CH_TAB: begin
              if (spaces != 9'd0) begin
                cmd.kind  = K_SPACES;
                cmd.count = spaces[CNT_W-1:0];
              end
              if (tab_sum >= {1'b0, columns}) begin
                col_next = 8'd0;
                row_next = row_adv;
              end else begin
                col_next = tab_sum[7:0];
              end
            end
            CH_BS: begin
              if (col != 8'd0) begin
                cmd.kind  = K_BSSEQ;
                cmd.count = CNT_W'(BS_LEN);
                col_next  = col - 8'd1;
              end
            end
            default: begin
              if (ch >= CH_SPACE && ch < CH_DEL) begin
                cmd.kind = K_ECHO;
                if (col_inc >= {1'b0, columns}) begin
                  col_next = 8'd0;
                  row_next = row_adv;
                end else begin
                  col_next = col_inc[7:0];
                end
              end
            end
          endcase
        end
        if (s_tlast) disc_next = 1'b0;
      end
      MODE_CLEAR: begin
        cmd.kind  = K_CLEAR;
        cmd.count = CNT_W'(CLEAR_LEN);
        col_next  = 8'd0;
        row_next  = 8'd0;
        disc_next = 1'b0;
      end
      MODE_CURSOR: begin
        if (new_col < columns) col_next = new_col;
        if (new_row < rows) row_next = new_row;
        disc_next = 1'b0;
      end
      default: begin
      end
    endcase
    cmd.col = col_next;
    cmd.row = row_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= 8'd0;
      row     <= 8'd0;
      disc    <= 1'b0;
      columns <= COLUMNS_RST;
      rows    <= ROWS_RST;
    end else begin
      if (accept) begin
        col  <= col_next;
        row  <= row_next;
        disc <= disc_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLUMNS: columns <= cfg_data;
          REG_ROWS:    rows    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  `TCCE_ASSERT(a_clear_homes, clk, rst, accept && (mode == MODE_CLEAR) |=> (col == 8'd0) && (row == 8'd0) && !disc)

endmodule

[design/tcce_queue.sv]
// ----------------------------------------------------------------------------
// Cursor engine command queue
// Two-entry queue that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
module tcce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcce_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output tcce_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import tcce_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[design/tcce_back.sv]
// ----------------------------------------------------------------------------
// Cursor engine byte sequencer
// Plays each queued command out as one or more output beats.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_core_macros.svh"

module tcce_back (
  input  logic           clk,
  input  logic           rst,
  input  tcce_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [23:0]    m_tdata,   // out_byte[7:0], cursor_col[15:8], cursor_row[23:16]
  output logic           m_tuser,   // byte_valid
  output logic           m_tlast    // last
);
  import tcce_pkg::*;

  cmd_t             cur;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             beat;
  logic             at_end;
  logic             load;
  logic [7:0]       out_byte;

  assign beat    = busy && m_tready;
  assign at_end  = ({1'b0, idx} + CNT_W'(1)) == cur.count;
  assign load    = cmd_valid && (!busy || (beat && at_end));
  assign cmd_pop = load;

  always_comb begin
    case (cur.kind)
      K_ECHO:   out_byte = cur.ch;
      K_SPACES: out_byte = CH_SPACE;
      K_BSSEQ:  out_byte = (idx == IDX_W'(1)) ? CH_SPACE : CH_BS;
      K_CLEAR:  out_byte = clear_byte(idx);
      default:  out_byte = 8'h00;
    endcase
  end

  assign m_tvalid = busy;
  assign m_tdata  = {cur.row, cur.col, out_byte};
  assign m_tuser  = (cur.kind != K_STATUS);
  assign m_tlast  = at_end;

  always_ff @(posedge clk) begin
    if (load) cur <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (beat && !at_end) begin
      idx <= idx + IDX_W'(1);
    end else if (!busy || beat) begin
      busy <= cmd_valid;
      idx  <= '0;
    end
  end

  `TCCE_ASSERT(a_idx_in_range, clk, rst, busy |-> ({1'b0, idx} < cur.count))
  `TCCE_ASSERT_NEVER(a_status_clean, clk, rst, busy && !m_tuser && ((out_byte != 8'h00) || !m_tlast))
  `TCCE_ASSERT(a_chain_next, clk, rst, beat && at_end && cmd_valid |=> busy && (idx == '0))

endmodule

[design/text_console_cursor_engine_core.sv]
// A result's first beat is offered once its command has passed a queue slot and the
// sequencer's register. Throughput: the sequencer sends one beat per cycle while the
// receiver is ready; an item causes 1 to 8 beats (8 full tab, 7 clear, 3 backspace).
// The front end takes an item per cycle while its two-entry command queue has room.
// Reset clears cursor, discard flag, queue and sequencer; columns returns to 80, rows to 25.
// ----------------------------------------------------------------------------
// Text console cursor engine
// Turns console characters and commands into serial bytes with cursor status.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core #(
  parameter int unsigned TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // mode[1:0], char_code[9:2], new_col[17:10], new_row[25:18]
  input  logic        s_tlast,   // last_of_request
  // Result beats.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte[7:0], cursor_col[15:8], cursor_row[23:16]
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast,   // last
  // Configuration writes: index 0 is columns, index 1 is rows.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import tcce_pkg::*;

  // The front end decides the whole effect of an item in the cycle it is
  // accepted: the new cursor, the discard flag, and which byte sequence to
  // send. That decision travels as a compact command, so a long sequence
  // such as a clear never holds up classification of the next item.
  cmd_t front_cmd;
  logic front_valid;
  logic q_full;
  cmd_t back_cmd;
  logic q_empty;
  logic back_pop;

  tcce_front #(
    .TAB_STOP (TAB_STOP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (!q_full)
  );

  // The queue lets the front end keep accepting items while the output side
  // is stalled or busy with a multi-beat sequence.
  tcce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_valid),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (back_pop),
    .pop_cmd  (back_cmd),
    .empty    (q_empty)
  );

  // The sequencer holds the current command in a register and steps a beat
  // index through it; every beat carries the cursor as it stands after the
  // whole item, and the final beat of the command raises tlast.
  tcce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (!q_empty),
    .cmd_pop   (back_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[test/tcce_cursor_monitor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cursor engine stream monitor
// Watches the item, result and register ports of the cursor engine. It keeps
// its own cursor and size state, works out the beats each accepted item
// should cause, and compares every result beat with them in order.
// ----------------------------------------------------------------------------
module tcce_cursor_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // mode[1:0], char_code[9:2], new_col[17:10], new_row[25:18]
  input  logic        s_tlast,   // last_of_request
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // out_byte[7:0], cursor_col[15:8], cursor_row[23:16]
  input  logic        m_tuser,   // byte_valid
  input  logic        m_tlast,   // last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          beats_due
);
  import tcce_pkg::*;

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_TWO      = 8'h32;
  localparam logic [7:0] CH_J        = 8'h4A;
  localparam logic [7:0] CH_H        = 8'h48;
  // ESC [ 2 J ESC [ H, first byte in the lowest bits.
  localparam logic [55:0] CLEAR_SEQ = {CH_H, CH_LBRACKET, CH_ESC, CH_J, CH_TWO,
                                       CH_LBRACKET, CH_ESC};
  localparam int MAX_SHOWN = 100;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
  } console_beat_t;

  console_beat_t due_console_beats[$];
  logic [7:0]    columns_q;
  logic [7:0]    rows_q;
  logic [7:0]    col_q;
  logic [7:0]    row_q;
  logic          discard_q;
  int            beat_no;

  task automatic report_mismatch(input string what, input int want, input int got);
    if (fail_count < MAX_SHOWN)
      $display("ERROR at %0t, beat %0d: %s expected 0x%0h, got 0x%0h",
               $time, beat_no, what, want, got);
    fail_count++;
  endtask

  // Next row, held at the last row of the screen (row 0 when rows is zero).
  function automatic logic [7:0] next_row(input logic [7:0] row);
    int last_r;
    int r;
    last_r = (rows_q == 0) ? 0 : rows_q - 1;
    r = row + 1;
    if (r > last_r) r = last_r;
    return r[7:0];
  endfunction

  function automatic void console_echo_predict(input logic [1:0] mode, input logic [7:0] ch,
                                               input logic end_req, input logic [7:0] nc,
                                               input logic [7:0] nr);
    logic [7:0]    sent[$];
    int            c;
    int            stop;
    console_beat_t b;
    case (mode)
      MODE_WRITE: begin
        if (!discard_q) begin
          if (ch == CH_NUL) begin
            discard_q = 1'b1;
          end else if (ch == CH_LF) begin
            sent.push_back(CH_LF);
            col_q = 8'd0;
            row_q = next_row(row_q);
          end else if (ch == CH_CR) begin
            col_q = 8'd0;
          end else if (ch == CH_TAB) begin
            // Spaces up to the next tab stop, cut short at the right margin and the beat budget.
            c = col_q;
            stop = c + TAB_STOP_DEF - (c % TAB_STOP_DEF);
            while (c < stop && c < columns_q && sent.size() < MAX_RESULTS) begin
              sent.push_back(CH_SPACE);
              c++;
            end
            if (c >= columns_q) begin
              c = 0;
              row_q = next_row(row_q);
            end
            col_q = c[7:0];
          end else if (ch == CH_BS) begin
            if (col_q > 0) begin
              col_q = col_q - 1;
              sent.push_back(CH_BS);
              sent.push_back(CH_SPACE);
              sent.push_back(CH_BS);
            end
          end else if (ch >= CH_SPACE && ch < CH_DEL) begin
            sent.push_back(ch);
            c = col_q + 1;
            if (c >= columns_q) begin
              c = 0;
              row_q = next_row(row_q);
            end
            col_q = c[7:0];
          end
        end
        if (end_req) discard_q = 1'b0;
      end
      MODE_CLEAR: begin
        for (int k = 0; k < CLEAR_LEN; k++) sent.push_back(CLEAR_SEQ[8*k +: 8]);
        col_q = 8'd0;
        row_q = 8'd0;
        discard_q = 1'b0;
      end
      MODE_CURSOR: begin
        if (nc < columns_q) col_q = nc;
        if (nr < rows_q) row_q = nr;
        discard_q = 1'b0;
      end
      default: ;  // unused mode: status only, nothing changes
    endcase

    b.cursor_col = col_q;
    b.cursor_row = row_q;
    if (sent.size() == 0) begin
      b.out_byte = 8'd0;
      b.byte_valid = 1'b0;
      b.last = 1'b1;
      due_console_beats.push_back(b);
    end else begin
      for (int k = 0; k < sent.size(); k++) begin
        b.out_byte = sent[k];
        b.byte_valid = 1'b1;
        b.last = (k == sent.size() - 1);
        due_console_beats.push_back(b);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      columns_q = COLUMNS_RST;
      rows_q = ROWS_RST;
      col_q = 8'd0;
      row_q = 8'd0;
      discard_q = 1'b0;
      beat_no = 0;
      due_console_beats.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_COLUMNS) columns_q = cfg_data;
        else rows_q = cfg_data;
      end
      if (s_tvalid && s_tready)
        console_echo_predict(s_tdata[1:0], s_tdata[9:2], s_tlast, s_tdata[17:10],
                             s_tdata[25:18]);
      if (m_tvalid && m_tready) begin
        if (due_console_beats.size() == 0) begin
          report_mismatch("result beat with nothing pending, out_byte", 0, m_tdata[7:0]);
        end else begin
          console_beat_t want;
          want = due_console_beats.pop_front();
          if (m_tdata[7:0] !== want.out_byte)
            report_mismatch("out_byte", want.out_byte, m_tdata[7:0]);
          if (m_tuser !== want.byte_valid)
            report_mismatch("byte_valid", want.byte_valid, m_tuser);
          if (m_tlast !== want.last)
            report_mismatch("last", want.last, m_tlast);
          if (m_tdata[15:8] !== want.cursor_col)
            report_mismatch("cursor_col", want.cursor_col, m_tdata[15:8]);
          if (m_tdata[23:16] !== want.cursor_row)
            report_mismatch("cursor_row", want.cursor_row, m_tdata[23:16]);
        end
        beat_no++;
      end
    end
    beats_due = due_console_beats.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cursor engine testbench
// Drives console items and register writes into the cursor engine with
// random gaps and output stalls; the stream monitor predicts and checks the
// result beats, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import tcce_pkg::*;

  // The fourth mode value has no meaning; the engine answers it with a status beat.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         RANDOM_ITEMS = 195;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  int          fail_count;
  int          beats_due;
  // When clear, neither side inserts gaps or stalls.
  logic        gaps_on;
  // The size last written, so cursor commands can aim mostly inside the screen.
  logic [7:0]  cols_now;
  logic [7:0]  rows_now;
  int          useful_items;

  text_console_cursor_engine_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tcce_cursor_monitor u_mon (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .beats_due (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // While gaps are on, the receiver stalls at random with odds of about 38 in a hundred.
  initial m_tready = 1'b0;
  always @(negedge clk) begin
    m_tready <= !(gaps_on && $urandom_range(99) < 38);
  end

  // Hard stop in case the engine hangs or holds back beats.
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Offers one item and returns at the falling edge after it was taken.
  // The valid stays high so that back-to-back items need no extra edge.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] ch, input logic end_req,
                           input logic [7:0] nc, input logic [7:0] nr);
    while (gaps_on && $urandom_range(99) < 38) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {6'b0, nr, nc, ch, mode};
    s_tlast = end_req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write beat: the unused coordinate fields carry random bits.
  task automatic send_char(input logic [7:0] ch, input logic end_req);
    send_item(MODE_WRITE, ch, end_req, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_cursor(input logic [7:0] nc, input logic [7:0] nr);
    send_item(MODE_CURSOR, 8'($urandom_range(255)), 1'($urandom_range(1)), nc, nr);
  endtask

  // Stops sending and waits until every predicted beat has come back, then keeps
  // watching with no input so a stray extra beat would still be seen.
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Registers are only written with the engine idle.
  task automatic set_screen(input logic [7:0] cols, input logic [7:0] rws);
    drain_results();
    cfg_we = 1'b1;
    cfg_index = REG_COLUMNS;
    cfg_data = cols;
    @(negedge clk);
    cfg_index = REG_ROWS;
    cfg_data = rws;
    @(negedge clk);
    cfg_we = 1'b0;
    cols_now = cols;
    rows_now = rws;
  endtask

  // Mostly printable text, a fair share of control bytes, now and then a NUL
  // or any byte at all.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 8'($urandom_range(8'h7E, 8'h20));
    if (r < 58) return CH_LF;
    if (r < 64) return CH_CR;
    if (r < 74) return CH_TAB;
    if (r < 82) return CH_BS;
    if (r < 85) return CH_NUL;
    return 8'($urandom_range(255));
  endfunction

  // A coordinate usually inside the screen, sometimes anywhere in the byte.
  function automatic logic [7:0] pick_coord(input logic [7:0] size);
    if (size != 0 && $urandom_range(99) < 75) return 8'($urandom_range(size - 1));
    return 8'($urandom_range(255));
  endfunction

  // One random piece of traffic: a write request of a few characters (a few
  // of them left without their closing beat), or a single command.
  task automatic random_traffic();
    int r;
    int n;
    logic [7:0] ch;
    r = $urandom_range(99);
    if (r < 75) begin
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
        ch = pick_char();
        send_char(ch, (i == n - 1) && ($urandom_range(9) != 0));
        useful_items++;
      end
    end else if (r < 84) begin
      send_item(MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
      useful_items++;
    end else if (r < 97) begin
      send_cursor(pick_coord(cols_now), pick_coord(rows_now));
      useful_items++;
    end else begin
      send_item(MODE_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_COLUMNS;
    cfg_data = 8'd0;
    gaps_on = 1'b1;
    cols_now = COLUMNS_RST;
    rows_now = ROWS_RST;
    useful_items = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part on the reset screen size of 80 by 25. Printable bytes at
    // both ends of the range, bytes just outside it, backspace at a nonzero
    // column, a partial and a full tab, backspace at column zero, a newline.
    send_char(8'h41, 1'b0);
    send_char(8'h7E, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_DEL, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_BS, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_BS, 1'b0);
    send_char(CH_LF, 1'b1);
    // A NUL drops the rest of its request; the closing beat ends the drop.
    send_char(CH_NUL, 1'b0);
    send_char(8'h42, 1'b0);
    send_char(CH_LF, 1'b1);
    send_char(8'h43, 1'b1);
    // Clear, then a printable byte in the bottom right corner wraps and the
    // row stays clamped on the last row.
    send_item(MODE_CLEAR, 8'h00, 1'b0, 8'h00, 8'h00);
    send_cursor(8'd79, 8'd24);
    send_char(8'h5A, 1'b1);
    // Out-of-range coordinates are each ignored on their own.
    send_cursor(8'd80, 8'd25);
    send_cursor(8'hFF, 8'h00);
    send_item(MODE_UNUSED, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    // A cursor command also ends a drop.
    send_char(CH_NUL, 1'b0);
    send_cursor(8'd70, 8'd20);
    send_char(8'h44, 1'b0);

    // The screen shrinks under the cursor: it must wrap and clamp at once.
    set_screen(8'd10, 8'd5);
    send_char(8'h45, 1'b0);
    send_cursor(8'd9, 8'd4);
    send_char(CH_TAB, 1'b1);
    // Zero columns and zero rows: every printable byte and tab wraps, row stays 0.
    set_screen(8'd0, 8'd0);
    send_char(8'h46, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_LF, 1'b1);
    // Largest screen: a tab from column 254 emits one space and wraps.
    set_screen(8'd255, 8'd255);
    send_cursor(8'd254, 8'd254);
    send_char(CH_TAB, 1'b0);
    send_cursor(8'd250, 8'd254);
    send_char(CH_LF, 1'b1);

    // Random part in phases of different screen sizes.
    for (int phase = 0; useful_items < RANDOM_ITEMS; phase++) begin
      case (phase % 6)
        0: set_screen(8'd80, 8'd25);
        1: set_screen(8'd10, 8'd3);
        2: set_screen(8'd1, 8'd1);
        3: set_screen(8'd255, 8'd255);
        4: set_screen(8'($urandom_range(40, 2)), 8'($urandom_range(10, 2)));
        default: set_screen(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)));
      endcase
      // One phase runs with no gaps or stalls at all.
      gaps_on = (phase != 4);
      for (int i = 0; i < 10 && useful_items < RANDOM_ITEMS; i++) begin
        random_traffic();
        // Once, the sender holds off until every beat is back.
        if (phase == 1 && i == 5) drain_results();
      end
    end
    gaps_on = 1'b1;

    drain_results();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[text_console_cursor_engine_core.f]
+incdir+design
design/tcce_pkg.sv
design/tcce_front.sv
design/tcce_queue.sv
design/tcce_back.sv
design/text_console_cursor_engine_core.sv
test/tcce_cursor_monitor.sv
test/tb_top.sv
